>>> hw/rtl/riqcs_pkg.sv
`default_nettype none

package riqcs_pkg;

  // Current word width, signed 1/16 A
  localparam int CURRENT_BITS = 16;
  localparam int STEP_BITS    = 15;
  localparam int SPEED_BITS   = 16;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 16;

  // Working width for current arithmetic: two guard bits over the current word
  localparam int WIDE_BITS = CURRENT_BITS + 2;

  localparam int IN_DATA_BITS  = 40;
  localparam int OUT_DATA_BITS = 24;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_NEG_CURRENT_LIMIT = 3'd0,
    REG_TO_ZERO_STEP      = 3'd1,
    REG_TO_NEGATIVE_STEP  = 3'd2,
    REG_SLEW_LIMIT        = 3'd3,
    REG_RELEASE_SPEED     = 3'd4,
    REG_FORWARD_ONLY      = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_TO_ZERO = 3'd1,
    ST_PUSH    = 3'd2,
    ST_HOLD    = 3'd3,
    ST_UNWIND  = 3'd4
  } stage_t;

  typedef struct packed {
    logic signed [CURRENT_BITS-1:0] neg_current_limit;
    logic [STEP_BITS-1:0]           to_zero_step;
    logic [STEP_BITS-1:0]           to_negative_step;
    logic [STEP_BITS-1:0]           slew_limit;
    logic [STEP_BITS-1:0]           release_speed;
    logic                           fwd_only_en;
  } cfg_t;

  typedef struct packed {
    logic signed [CURRENT_BITS-1:0] iq_ref;
    logic signed [SPEED_BITS-1:0]   speed;
    logic                           forward;
    logic                           regen_req;
  } item_t;

  typedef struct packed {
    logic [2:0]                     phase;
    logic signed [CURRENT_BITS-1:0] iq_cmd;
  } result_t;

  localparam logic signed [CURRENT_BITS-1:0] NEG_LIMIT_RST = -16'sd960;
  localparam logic [STEP_BITS-1:0] TO_ZERO_RST   = 15'd16;
  localparam logic [STEP_BITS-1:0] TO_NEG_RST    = 15'd16;
  localparam logic [STEP_BITS-1:0] SLEW_RST      = 15'd32;
  localparam logic [STEP_BITS-1:0] RELEASE_RST   = 15'd300;

endpackage

`default_nettype wire

>>> hw/rtl/riqcs_cfg.sv
`default_nettype none

module riqcs_cfg
  import riqcs_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output cfg_t                          cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.neg_current_limit <= NEG_LIMIT_RST;
      cfg_r.to_zero_step      <= TO_ZERO_RST;
      cfg_r.to_negative_step  <= TO_NEG_RST;
      cfg_r.slew_limit        <= SLEW_RST;
      cfg_r.release_speed     <= RELEASE_RST;
      cfg_r.fwd_only_en       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_NEG_CURRENT_LIMIT: cfg_r.neg_current_limit <= cfg_wdata[CURRENT_BITS-1:0];
        REG_TO_ZERO_STEP:      cfg_r.to_zero_step      <= cfg_wdata[STEP_BITS-1:0];
        REG_TO_NEGATIVE_STEP:  cfg_r.to_negative_step  <= cfg_wdata[STEP_BITS-1:0];
        REG_SLEW_LIMIT:        cfg_r.slew_limit        <= cfg_wdata[STEP_BITS-1:0];
        REG_RELEASE_SPEED:     cfg_r.release_speed     <= cfg_wdata[STEP_BITS-1:0];
        REG_FORWARD_ONLY:      cfg_r.fwd_only_en       <= cfg_wdata[0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> hw/rtl/riqcs_seq.sv
`default_nettype none

module riqcs_seq
  import riqcs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire item_t item,
  input  wire logic  step_en,
  output result_t    res
);

  logic signed [CURRENT_BITS-1:0] cur_r, cur_nxt;
  stage_t                         stage_r, stage_nxt;

  logic                        regen_on;
  logic signed [WIDE_BITS-1:0] prev_x, ncl_x, zs_x, ns_x, sl_x, ref_x;
  logic signed [WIDE_BITS-1:0] prev_abs, tz_x, push_x, cmd_x, diff_x, sum_x;
  logic                        tz_done;
  logic signed [WIDE_BITS-1:0] sat_hi, sat_lo;

  always_comb begin
    regen_on = item.regen_req & (~cfg.fwd_only_en | item.forward);

    prev_x = WIDE_BITS'(cur_r);
    ncl_x  = WIDE_BITS'(cfg.neg_current_limit);
    zs_x   = WIDE_BITS'($signed({1'b0, cfg.to_zero_step}));
    ns_x   = WIDE_BITS'($signed({1'b0, cfg.to_negative_step}));
    sl_x   = WIDE_BITS'($signed({1'b0, cfg.slew_limit}));
    ref_x  = WIDE_BITS'(item.iq_ref);

    // step toward zero; done when it would reach or pass zero
    prev_abs = (prev_x < 0) ? -prev_x : prev_x;
    tz_done  = (prev_abs <= zs_x);
    tz_x     = tz_done ? '0 : ((prev_x > 0) ? prev_x - zs_x : prev_x + zs_x);

    // lower bound wins, upper bound zero only checked when not below lower
    push_x = prev_x - ns_x;
    if (push_x < ncl_x)       push_x = ncl_x;
    else if (push_x > 0)      push_x = '0;

    stage_nxt = stage_r;
    cmd_x     = ref_x;
    if (!regen_on && stage_r != ST_UNWIND) begin
      stage_nxt = ST_IDLE;
      cmd_x     = ref_x;
    end else begin
      case (stage_r)
        ST_IDLE, ST_TO_ZERO: begin
          stage_nxt = tz_done ? ST_PUSH : ST_TO_ZERO;
          cmd_x     = tz_x;
        end
        ST_PUSH: begin
          cmd_x     = push_x;
          stage_nxt = (push_x <= ncl_x) ? ST_HOLD : ST_PUSH;
        end
        ST_HOLD: begin
          if (prev_x < ncl_x)  cmd_x = ncl_x;
          else if (prev_x > 0) cmd_x = '0;
          else                 cmd_x = prev_x;
          stage_nxt = (WIDE_BITS'(item.speed) < WIDE_BITS'($signed({1'b0, cfg.release_speed})))
                      ? ST_UNWIND : ST_HOLD;
        end
        ST_UNWIND: begin
          cmd_x     = tz_x;
          stage_nxt = tz_done ? ST_IDLE : ST_UNWIND;
        end
        default: begin
          stage_nxt = ST_IDLE;
          cmd_x     = ref_x;
        end
      endcase
    end

    // slew limit, then saturate to the current word
    diff_x = cmd_x - prev_x;
    if (diff_x > sl_x)       diff_x = sl_x;
    else if (diff_x < -sl_x) diff_x = -sl_x;
    sum_x  = prev_x + diff_x;
    sat_hi = WIDE_BITS'({1'b0, {(CURRENT_BITS-1){1'b1}}});
    sat_lo = -sat_hi - WIDE_BITS'(1);
    if (sum_x > sat_hi)      cur_nxt = sat_hi[CURRENT_BITS-1:0];
    else if (sum_x < sat_lo) cur_nxt = sat_lo[CURRENT_BITS-1:0];
    else                     cur_nxt = sum_x[CURRENT_BITS-1:0];

    res.iq_cmd = cur_nxt;
    res.phase  = stage_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= '0;
      stage_r <= ST_IDLE;
    end else if (step_en) begin
      cur_r   <= cur_nxt;
      stage_r <= stage_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/regen_iq_current_sequencer_core.sv
`default_nettype none

// Regenerative q-axis current sequencer.
// in_*  : one request per control tick (decel flag, direction, speed, iq_ref).
// out_* : one result per request (slew-limited iq_cmd and the stage after it).
// cfg_* : register writes, one per cycle while cfg_we is high; the user must
//         write them only while the block is idle; the block does not enforce it.
// A request lands in the input register; on the next edge at which the result
// register is free or being drained, the sequencer runs on it, updates its
// stored current and stage, and loads the result register. A request passes the
// input register, then the result register; throughput is one request per cycle
// while out_tready is high, set by the loop through the stored current and stage.
// When out_tready is low the result register holds, the input register fills,
// and in_tready drops once both are occupied; nothing is lost or repeated.
// Reset (rst_n low at a clock edge) empties both registers, sets the stored
// current to zero, the stage to idle and all config registers to defaults.
module regen_iq_current_sequencer_core
  import riqcs_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // tdata: [0] regen_req, [1] forward, [17:2] speed, [33:18] iq_ref, rest zero
  input  wire logic [IN_DATA_BITS-1:0]  in_tdata,
  input  wire logic                     in_tvalid,
  output      logic                     in_tready,
  // tdata: [15:0] iq_cmd, [18:16] phase, rest zero
  output      logic [OUT_DATA_BITS-1:0] out_tdata,
  output      logic                     out_tvalid,
  input  wire logic                     out_tready,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  cfg_t    cfg;
  item_t   item_r;
  logic    item_vld_r;
  result_t res, res_r;
  logic    res_vld_r;
  logic    step_en;

  riqcs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // sequencer fires when an item waits and the result slot can take it
  assign step_en   = item_vld_r & (~res_vld_r | out_tready);
  assign in_tready = ~item_vld_r | step_en;

  riqcs_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .item    (item_r),
    .step_en (step_en),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      if (in_tready) item_vld_r <= in_tvalid;
      if (step_en)   res_vld_r  <= 1'b1;
      else if (out_tready) res_vld_r <= 1'b0;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.regen_req <= in_tdata[0];
      item_r.forward   <= in_tdata[1];
      item_r.speed     <= in_tdata[SPEED_BITS+1:2];
      item_r.iq_ref    <= in_tdata[SPEED_BITS+CURRENT_BITS+1:SPEED_BITS+2];
    end
    if (step_en) res_r <= res;
  end

  assign out_tvalid = res_vld_r;
  assign out_tdata  = {{(OUT_DATA_BITS-CURRENT_BITS-3){1'b0}}, res_r.phase, res_r.iq_cmd};

endmodule

`default_nettype wire

>>> tb/sv/regen_iq_current_sequencer_checker.sv
// Watches the request, result and register ports of the sequencer core,
// predicts every iq_cmd/phase pair and compares in order of arrival.
module regen_iq_current_sequencer_checker
  import riqcs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,
  input  logic                     in_tvalid,
  input  logic                     in_tready,
  input  logic [OUT_DATA_BITS-1:0] out_tdata,
  input  logic                     out_tvalid,
  input  logic                     out_tready,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output int                       fail_count,
  output int                       pending
);

  localparam int CUR_MAX = (1 << (CURRENT_BITS - 1)) - 1;
  localparam int CUR_MIN = -CUR_MAX - 1;

  cfg_t                           regs;
  logic signed [CURRENT_BITS-1:0] held_cur;
  stage_t                         stage;
  result_t                        pending_cmds[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("%0t checker: %s: got %0d, expected %0d", $time, what, got_v, want_v);
    fail_count++;
  endtask

  // One control tick: advances the held current and stage, returns the result.
  task automatic sequence_tick(input item_t it, output result_t r);
    int  ref_v, prev, cmd, t, d, lim, spd;
    int  zero_step, neg_step, slew, rel;
    bit  regen;
    ref_v     = $signed(it.iq_ref);
    spd       = $signed(it.speed);
    lim       = $signed(regs.neg_current_limit);
    zero_step = regs.to_zero_step;
    neg_step  = regs.to_negative_step;
    slew      = regs.slew_limit;
    rel       = regs.release_speed;
    prev      = $signed(held_cur);
    cmd       = ref_v;
    regen     = it.regen_req && (!regs.fwd_only_en || it.forward);

    if (!regen && stage != ST_UNWIND) begin
      stage = ST_IDLE;
      cmd   = ref_v;
    end else begin
      case (stage)
        ST_IDLE, ST_TO_ZERO: begin
          stage = ST_TO_ZERO;
          t = (prev > 0) ? prev - zero_step : prev + zero_step;
          if ((prev >= 0 && t <= 0) || (prev <= 0 && t >= 0)) begin
            t     = 0;
            stage = ST_PUSH;
          end
          cmd = t;
        end
        ST_PUSH: begin
          // lower bound first; zero only checked when not below it
          cmd = prev - neg_step;
          if (cmd < lim) cmd = lim;
          else if (cmd > 0) cmd = 0;
          if (cmd <= lim) stage = ST_HOLD;
        end
        ST_HOLD: begin
          cmd = prev;
          if (cmd < lim) cmd = lim;
          else if (cmd > 0) cmd = 0;
          if (spd < rel) stage = ST_UNWIND;
        end
        ST_UNWIND: begin
          t = (prev < 0) ? prev + zero_step : prev - zero_step;
          if ((prev <= 0 && t >= 0) || (prev >= 0 && t <= 0)) begin
            t     = 0;
            stage = ST_IDLE;
          end
          cmd = t;
        end
        default: begin
          stage = ST_IDLE;
          cmd   = ref_v;
        end
      endcase
    end

    d = cmd - prev;
    if (d > slew) d = slew;
    if (d < -slew) d = -slew;
    t = prev + d;
    if (t > CUR_MAX) t = CUR_MAX;
    if (t < CUR_MIN) t = CUR_MIN;
    held_cur = CURRENT_BITS'(t);
    r.iq_cmd = held_cur;
    r.phase  = stage;
  endtask

  always @(posedge clk) begin : watch
    result_t got, want;
    item_t   it;
    if (!rst_n) begin
      regs.neg_current_limit = NEG_LIMIT_RST;
      regs.to_zero_step      = TO_ZERO_RST;
      regs.to_negative_step  = TO_NEG_RST;
      regs.slew_limit        = SLEW_RST;
      regs.release_speed     = RELEASE_RST;
      regs.fwd_only_en       = 1'b0;
      held_cur = '0;
      stage    = ST_IDLE;
      pending_cmds.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[$bits(result_t)-1:0]);
        if (pending_cmds.size() == 0) begin
          report_mismatch("result with no request outstanding, iq_cmd",
                          $signed(got.iq_cmd), 0);
        end else begin
          want = pending_cmds.pop_front();
          if (got.iq_cmd !== want.iq_cmd)
            report_mismatch("iq_cmd", $signed(got.iq_cmd), $signed(want.iq_cmd));
          if (got.phase !== want.phase)
            report_mismatch("phase", got.phase, want.phase);
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_NEG_CURRENT_LIMIT: regs.neg_current_limit = cfg_wdata;
          REG_TO_ZERO_STEP:      regs.to_zero_step      = cfg_wdata[STEP_BITS-1:0];
          REG_TO_NEGATIVE_STEP:  regs.to_negative_step  = cfg_wdata[STEP_BITS-1:0];
          REG_SLEW_LIMIT:        regs.slew_limit        = cfg_wdata[STEP_BITS-1:0];
          REG_RELEASE_SPEED:     regs.release_speed     = cfg_wdata[STEP_BITS-1:0];
          REG_FORWARD_ONLY:      regs.fwd_only_en       = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        it = item_t'(in_tdata[$bits(item_t)-1:0]);
        sequence_tick(it, want);
        pending_cmds.push_back(want);
      end
    end
    pending = pending_cmds.size();
  end

endmodule

>>> tb/sv/regen_iq_current_sequencer_core_test.sv
// Top of the sequencer core bench: clock, reset, request stimulus, result
// back-pressure, register phases and the verdict. All checking lives in the
// checker instance beside the core.
module regen_iq_current_sequencer_core_test;
  import riqcs_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int CYCLE_LIMIT   = 400000;  // far above the slowest legal run
  localparam int HOLD_CYCLES   = 64;      // long receiver hold-off
  localparam int SETTLE_CYCLES = 8;       // margin before the verdict

  // addresses with no register behind them
  localparam logic [CFG_ADDR_BITS-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_ADDR_BITS-1:0] REG_UNUSED_HI = 3'd7;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic [IN_DATA_BITS-1:0]  in_tdata;
  logic                     in_tvalid;
  wire                      in_tready;
  wire  [OUT_DATA_BITS-1:0] out_tdata;
  wire                      out_tvalid;
  logic                     out_tready;
  logic                     cfg_we;
  logic [CFG_ADDR_BITS-1:0] cfg_addr;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  int   fail_count;
  int   pending;
  int   cycle_cnt = 0;
  int   hold_reqs = 0;    // bumped to ask the receiver for one long hold-off
  int   burst_left = 0;   // requests left in the current sender burst
  cfg_t cur_cfg;          // what the registers hold now, to shape stimulus

  always #(HALF_PERIOD) clk = ~clk;

  regen_iq_current_sequencer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  regen_iq_current_sequencer_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Hard stop if the run hangs.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[regen_iq_current_sequencer_core] ERROR");
      $finish;
    end
  end

  // Receiver: segments of random stall modes; a long hold-off on demand.
  initial begin : receiver
    int seen, seg_left, mode, tick;
    seen       = 0;
    seg_left   = 0;
    mode       = 0;
    tick       = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != seen) begin
        // hold long enough for the core to fill and drop in_tready
        seen = hold_reqs;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 3);
        seg_left = $urandom_range(10, 80);
      end
      seg_left--;
      tick++;
      case (mode)
        0:       out_tready <= 1'b1;                        // no stalls
        1:       out_tready <= 1'($urandom_range(0, 1));    // coin toss
        2:       out_tready <= (tick % 4) != 0;             // fixed pattern
        default: out_tready <= $urandom_range(0, 7) == 0;   // mostly stalled
      endcase
    end
  end

  function automatic item_t make_tick(input bit decel, input bit fwd, input int spd,
                                      input int iq);
    item_t it;
    it.regen_req = decel;
    it.forward   = fwd;
    it.speed     = SPEED_BITS'(spd);
    it.iq_ref    = CURRENT_BITS'(iq);
    return it;
  endfunction

  // Offer one request; the sender opens a random gap between bursts.
  task automatic push_tick(input item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        in_tdata  <= IN_DATA_BITS'({$urandom, $urandom});  // junk while idle
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_BITS - $bits(item_t)){1'b0}}, it};
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  // Sender is already quiet; poll off-edge until every result is back.
  task automatic wait_drained();
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Core must be idle. Unused high data bits get noise.
  task automatic load_config(input cfg_t c, input bit poke_unused);
    cur_cfg = c;
    write_reg(REG_NEG_CURRENT_LIMIT, c.neg_current_limit);
    write_reg(REG_TO_ZERO_STEP,      {1'($urandom_range(0, 1)), c.to_zero_step});
    write_reg(REG_TO_NEGATIVE_STEP,  {1'($urandom_range(0, 1)), c.to_negative_step});
    write_reg(REG_SLEW_LIMIT,        {1'($urandom_range(0, 1)), c.slew_limit});
    write_reg(REG_RELEASE_SPEED,     {1'($urandom_range(0, 1)), c.release_speed});
    write_reg(REG_FORWARD_ONLY,      {15'($urandom), c.fwd_only_en});
    if (poke_unused) begin
      write_reg(REG_UNUSED_LO, CFG_DATA_BITS'($urandom));
      write_reg(REG_UNUSED_HI, CFG_DATA_BITS'($urandom));
    end
    cfg_we <= 1'b0;
  endtask

  function automatic cfg_t random_config();
    cfg_t c;
    c.neg_current_limit = CURRENT_BITS'(-int'($urandom_range(0, 3000)));
    c.to_zero_step      = STEP_BITS'($urandom_range(1, 300));
    c.to_negative_step  = STEP_BITS'($urandom_range(1, 400));
    c.slew_limit        = STEP_BITS'($urandom_range(1, 1000));
    c.release_speed     = STEP_BITS'($urandom_range(0, 3000));
    c.fwd_only_en       = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // Mostly regen episodes (decel held, speed high then low so the sequence
  // runs push, hold and unwind), with stray bits and fully random requests.
  // Optionally starts under a long receiver hold-off, and always drains once
  // halfway through with the sender paused.
  task automatic run_random(input int n_items, input bit with_hold);
    int sent, len, fast_len, k, spd;
    bit decel, fwd;
    sent = 0;
    if (with_hold) begin
      hold_reqs  <= hold_reqs + 1;
      burst_left = 40;  // keep offering back to back through the hold
    end
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 7) begin
        len      = $urandom_range(5, 80);
        fast_len = $urandom_range(0, len);
        for (k = 0; k < len && sent < n_items; k++) begin
          decel = 1'b1;
          fwd   = cur_cfg.fwd_only_en ? 1'b1 : 1'($urandom_range(0, 1));
          if ($urandom_range(0, 15) == 0) decel = 1'b0;
          if ($urandom_range(0, 15) == 0) fwd = 1'b0;
          if (k < fast_len) begin
            spd = int'(cur_cfg.release_speed) + int'($urandom_range(0, 3000));
            if (spd > 32767) spd = 32767;
          end else begin
            spd = int'(cur_cfg.release_speed) - int'($urandom_range(1, 600));
          end
          push_tick(make_tick(decel, fwd, spd, $urandom));
          sent++;
          if (sent == n_items / 2) begin
            in_tvalid <= 1'b0;
            wait_drained();
            burst_left = 0;
          end
        end
      end else begin
        len = $urandom_range(1, 15);
        for (k = 0; k < len && sent < n_items; k++) begin
          push_tick(make_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              $urandom, $urandom));
          sent++;
          if (sent == n_items / 2) begin
            in_tvalid <= 1'b0;
            wait_drained();
            burst_left = 0;
          end
        end
      end
    end
    in_tvalid <= 1'b0;
    wait_drained();
  endtask

  initial begin : stimulus
    int p;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: big steps, widest slew limit, forward only, so each stage is
    // reached in a handful of ticks.
    load_config('{-16'sd960, 15'd300, 15'd400, 15'd32767, 15'd300, 1'b1}, 1'b0);
    push_tick(make_tick(0, 0, 0, 32767));        // pass-through, top extreme
    push_tick(make_tick(0, 1, -32768, -32768));  // pass-through, bottom extreme
    push_tick(make_tick(1, 0, 100, 0));          // regen blocked by direction
    push_tick(make_tick(0, 0, 0, 700));
    push_tick(make_tick(1, 1, 32767, -5));       // idle starts ramp to zero
    push_tick(make_tick(1, 1, 32767, 0));
    push_tick(make_tick(1, 1, 32767, 0));        // step passes zero, push begins
    push_tick(make_tick(1, 1, 32767, 0));
    push_tick(make_tick(1, 1, 32767, 0));
    push_tick(make_tick(1, 1, 32767, 0));        // clamps onto the limit, hold
    push_tick(make_tick(1, 1, 300, 0));          // speed equal to release: stay
    push_tick(make_tick(1, 1, -32768, 0));       // below release: unwind
    push_tick(make_tick(0, 0, 5000, 12345));     // regen off, unwind continues
    push_tick(make_tick(1, 0, 5000, -1));        // blocked, unwind continues
    push_tick(make_tick(1, 1, 5000, 0));
    push_tick(make_tick(1, 1, 5000, 0));         // unwind lands on zero, idle
    push_tick(make_tick(1, 1, 5000, 0));         // ramp from exactly zero
    push_tick(make_tick(1, 1, 5000, 0));
    push_tick(make_tick(0, 1, 0, -32768));       // drop out of push
    push_tick(make_tick(1, 1, 0, 0));            // ramp up from most negative
    push_tick(make_tick(0, 0, 32767, 32767));
    in_tvalid <= 1'b0;
    wait_drained();

    // Defaults, unused addresses poked, long hold-off under full load.
    load_config('{NEG_LIMIT_RST, TO_ZERO_RST, TO_NEG_RST, SLEW_RST, RELEASE_RST, 1'b0},
                1'b1);
    run_random(150, 1'b1);

    // Upper extremes of the step, slew and release registers; limit at its most negative.
    load_config('{16'sh8000, 15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff, 1'b1}, 1'b0);
    run_random(80, 1'b0);

    // Lower extremes: output frozen, zero steps.
    load_config('0, 1'b0);
    run_random(60, 1'b0);

    // Limit above zero: the clamp lands on the limit below it, zero above it.
    load_config('{16'sd100, 15'd50, 15'd50, 15'd64, 15'd1000, 1'b0}, 1'b0);
    run_random(40, 1'b0);

    for (p = 0; p < 4; p++) begin
      load_config(random_config(), 1'b0);
      run_random(90, p == 2);
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[regen_iq_current_sequencer_core] OK");
    end else begin
      $display("[regen_iq_current_sequencer_core] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/riqcs_pkg.sv
hw/rtl/riqcs_cfg.sv
hw/rtl/riqcs_seq.sv
hw/rtl/regen_iq_current_sequencer_core.sv
tb/sv/regen_iq_current_sequencer_checker.sv
tb/sv/regen_iq_current_sequencer_core_test.sv
